/* src/gso_pkg.sv */
// Shared types, constants and helpers of the Gram-Schmidt orthonormaliser.
`default_nettype none
package gso_pkg;

    localparam int GSO_MAX_ROWS  = 8;
    localparam int GSO_MAX_COLS  = 4;
    localparam int GSO_FRAC_BITS = 28;

    localparam int VAL_W = 32;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_ORTHO = 2'd1,
        CMD_READ  = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    localparam logic KIND_READ = 1'b0;
    localparam logic KIND_DONE = 1'b1;

    localparam logic [1:0] CFG_ROWS  = 2'd0;
    localparam logic [1:0] CFG_COLS  = 2'd1;
    localparam logic [1:0] CFG_FLOOR = 2'd2;

    localparam logic signed [63:0] SAT_HI = 64'sd2147483647;
    localparam logic signed [63:0] SAT_LO = -64'sd2147483648;

    // start strobes for the root / divide unit
    typedef struct packed {
        logic start_sqrt;
        logic start_div;
    } t_sd_ctrl;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        logic signed [31:0] y;
        if (x > SAT_HI) begin
            y = 32'sh7FFFFFFF;
        end else if (x < SAT_LO) begin
            y = 32'sh80000000;
        end else begin
            y = x[31:0];
        end
        return y;
    endfunction

endpackage
`default_nettype wire

/* src/gram_schmidt_orthonormalizer.sv */
// Top level: matrix store, command sequencer and modified Gram-Schmidt run.
//
//  channel  | dir | handshake                       | payload
//  ---------+-----+---------------------------------+-------------------------------
//  s_axis   | in  | i_s_axis_tvalid/o_s_axis_tready | tdata row,col,value; tuser cmd
//  m_axis   | out | o_m_axis_tvalid/i_m_axis_tready | tdata data; tuser kind
//  cfg      | in  | i_cfg_valid/o_cfg_ready         | i_cfg_index, i_cfg_data
//
// A write request goes straight into the store; a read request passes through the
// store's read register and S_READ to the result register. An orthonormalise request
// works the columns in turn on the single multiplier and the bit-serial root and
// divide unit, and divides a column by its norm only when the norm clears the floor.
// Reset (synchronous, active low) clears the sequencer, the result valid and the
// configuration registers; the store is not cleared. Requests wait while a run is
// in progress or while an unclaimed result sits in the output register.
`default_nettype none
module gram_schmidt_orthonormalizer #(
    parameter int MAX_ROWS  = gso_pkg::GSO_MAX_ROWS,
    parameter int MAX_COLS  = gso_pkg::GSO_MAX_COLS,
    parameter int FRAC_BITS = gso_pkg::GSO_FRAC_BITS
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [39:0] i_s_axis_tdata,   // row[2:0], col[4:3], value[36:5], zero
    input  wire logic [1:0]  i_s_axis_tuser,   // command[1:0]
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic      [31:0] o_m_axis_tdata,   // data[31:0]
    output logic             o_m_axis_tuser,   // kind[0]
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);

    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = $clog2(DEPTH);
    localparam int RW    = $clog2(MAX_ROWS);
    localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

    typedef enum logic [17:0] {
        S_IDLE    = 18'b000000000000000001,
        S_READ    = 18'b000000000000000010,
        S_DOT_RD  = 18'b000000000000000100,
        S_DOT_MUL = 18'b000000000000001000,
        S_DOT_RND = 18'b000000000000010000,
        S_DOT_ACC = 18'b000000000000100000,
        S_PRJ_RD  = 18'b000000000001000000,
        S_PRJ_MUL = 18'b000000000010000000,
        S_PRJ_RND = 18'b000000000100000000,
        S_PRJ_WR  = 18'b000000001000000000,
        S_SQ_RD   = 18'b000000010000000000,
        S_SQ_MUL  = 18'b000000100000000000,
        S_SQ_RND  = 18'b000001000000000000,
        S_SQ_ACC  = 18'b000010000000000000,
        S_SQRT    = 18'b000100000000000000,
        S_DIV_RD  = 18'b001000000000000000,
        S_DIV_GO  = 18'b010000000000000000,
        S_DIV     = 18'b100000000000000000
    } t_state;

    function automatic logic [AW-1:0] f_addr(input int r, input int c);
        return AW'(r * MAX_COLS + c);
    endfunction

    // request fields
    logic        [2:0]  in_row;
    logic        [1:0]  in_col;
    logic signed [31:0] in_value;
    gso_pkg::t_cmd      in_cmd;
    logic               in_inside;
    logic               in_acc;

    assign in_row    = i_s_axis_tdata[2:0];
    assign in_col    = i_s_axis_tdata[4:3];
    assign in_value  = i_s_axis_tdata[36:5];
    assign in_cmd    = gso_pkg::t_cmd'(i_s_axis_tuser);
    assign in_inside = (int'(in_row) < MAX_ROWS) && (int'(in_col) < MAX_COLS);

    t_state             r_state, n_state;
    logic [RW-1:0]      r_l, n_l, r_l_last, n_l_last;
    logic [CW-1:0]      r_i, n_i, r_j, n_j, r_j_last, n_j_last;
    logic signed [63:0] r_acc, n_acc;
    logic signed [31:0] r_coef, n_coef, r_elem, n_elem;
    logic [47:0]        r_norm, n_norm;
    logic               r_in_ok, n_in_ok;
    logic               r_out_valid, n_out_valid;
    logic [31:0]        r_out_data, n_out_data;
    logic               r_out_kind, n_out_kind;
    logic [3:0]         r_rows;
    logic [2:0]         r_cols;
    logic [15:0]        r_floor;

    // store and arithmetic
    logic               ram_we;
    logic [AW-1:0]      ram_waddr, ram_raddr_a, ram_raddr_b;
    logic [31:0]        ram_wdata, rd_a, rd_b;
    logic signed [31:0] mul_a, mul_b;
    logic signed [63:0] mul_rnd;
    logic signed [63:0] acc_sum;
    gso_pkg::t_sd_ctrl  sd_ctrl;
    logic               sd_busy;
    logic [47:0]        sd_root;
    logic signed [31:0] sd_quot;

    gso_ram #(.WIDTH(gso_pkg::VAL_W), .DEPTH(DEPTH)) u_ram (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_waddr   (ram_waddr),
        .i_wdata   (ram_wdata),
        .i_raddr_a (ram_raddr_a),
        .o_rdata_a (rd_a),
        .i_raddr_b (ram_raddr_b),
        .o_rdata_b (rd_b)
    );

    gso_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_rnd (mul_rnd)
    );

    gso_sqdiv #(.FRAC_BITS(FRAC_BITS)) u_sqdiv (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (sd_ctrl),
        .i_radicand (64'(acc_sum)),
        .i_dividend (rd_a),
        .i_divisor  (r_norm),
        .o_busy     (sd_busy),
        .o_root     (sd_root),
        .o_quot     (sd_quot)
    );

    // requests wait while busy or while a result is unclaimed
    assign o_s_axis_tready = (r_state == S_IDLE) && (!r_out_valid || i_m_axis_tready);
    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;
    assign o_cfg_ready     = 1'b1;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_kind;
    assign acc_sum         = r_acc + mul_rnd;

    always_comb begin
        ram_raddr_a = f_addr(int'(r_l), int'(r_j));
        ram_raddr_b = f_addr(int'(r_l), int'(r_i));
        ram_waddr   = f_addr(int'(r_l), int'(r_j));
        ram_wdata   = sd_quot;
        ram_we      = 1'b0;
        mul_a       = rd_a;
        mul_b       = rd_b;
        if (r_state == S_IDLE) begin
            ram_raddr_a = f_addr(int'(in_row), int'(in_col));
            ram_waddr   = f_addr(int'(in_row), int'(in_col));
            ram_wdata   = in_value;
            ram_we      = in_acc && in_cmd == gso_pkg::CMD_WRITE && in_inside;
        end else if (r_state == S_PRJ_WR) begin
            ram_wdata = gso_pkg::sat32(64'(r_elem) - mul_rnd);
            ram_we    = 1'b1;
        end else if (r_state == S_DIV) begin
            ram_we = !sd_busy;
        end
        if (r_state == S_PRJ_MUL) begin
            mul_a = r_coef;
        end else if (r_state == S_SQ_MUL) begin
            mul_b = rd_a;
        end
    end

    always_comb begin
        int rows_i;
        int cols_i;
        n_state     = r_state;
        n_l         = r_l;
        n_i         = r_i;
        n_j         = r_j;
        n_l_last    = r_l_last;
        n_j_last    = r_j_last;
        n_acc       = r_acc;
        n_coef      = r_coef;
        n_elem      = r_elem;
        n_norm      = r_norm;
        n_in_ok     = r_in_ok;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        n_out_kind  = r_out_kind;
        sd_ctrl     = '0;
        rows_i      = int'(r_rows);
        cols_i      = int'(r_cols);

        if (r_out_valid && i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    case (in_cmd)
                        gso_pkg::CMD_READ: begin
                            n_in_ok = in_inside;
                            n_state = S_READ;
                        end
                        gso_pkg::CMD_ORTHO: begin
                            // clamp the register counts into the store's range
                            if (rows_i < 1) begin
                                n_l_last = '0;
                            end else if (rows_i > MAX_ROWS) begin
                                n_l_last = RW'(MAX_ROWS - 1);
                            end else begin
                                n_l_last = RW'(rows_i - 1);
                            end
                            if (cols_i < 1) begin
                                n_j_last = '0;
                            end else if (cols_i > MAX_COLS) begin
                                n_j_last = CW'(MAX_COLS - 1);
                            end else begin
                                n_j_last = CW'(cols_i - 1);
                            end
                            n_l     = '0;
                            n_i     = '0;
                            n_j     = '0;
                            n_acc   = '0;
                            n_state = S_SQ_RD;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_READ: begin
                n_out_valid = 1'b1;
                n_out_kind  = gso_pkg::KIND_READ;
                n_out_data  = r_in_ok ? rd_a : '0;
                n_state     = S_IDLE;
            end
            S_DOT_RD:  n_state = S_DOT_MUL;
            S_DOT_MUL: n_state = S_DOT_RND;
            S_DOT_RND: n_state = S_DOT_ACC;
            S_DOT_ACC: begin
                if (r_l == r_l_last) begin
                    n_coef  = gso_pkg::sat32(acc_sum);
                    n_l     = '0;
                    n_state = S_PRJ_RD;
                end else begin
                    n_acc   = acc_sum;
                    n_l     = r_l + 1'b1;
                    n_state = S_DOT_RD;
                end
            end
            S_PRJ_RD: n_state = S_PRJ_MUL;
            S_PRJ_MUL: begin
                n_elem  = rd_a;
                n_state = S_PRJ_RND;
            end
            S_PRJ_RND: n_state = S_PRJ_WR;
            S_PRJ_WR: begin
                if (r_l == r_l_last) begin
                    n_l   = '0;
                    n_acc = '0;
                    if (CW'(r_i + 1'b1) == r_j) begin
                        n_state = S_SQ_RD;
                    end else begin
                        n_i     = r_i + 1'b1;
                        n_state = S_DOT_RD;
                    end
                end else begin
                    n_l     = r_l + 1'b1;
                    n_state = S_PRJ_RD;
                end
            end
            S_SQ_RD:  n_state = S_SQ_MUL;
            S_SQ_MUL: n_state = S_SQ_RND;
            S_SQ_RND: n_state = S_SQ_ACC;
            S_SQ_ACC: begin
                if (r_l == r_l_last) begin
                    sd_ctrl.start_sqrt = 1'b1;
                    n_state            = S_SQRT;
                end else begin
                    n_acc   = acc_sum;
                    n_l     = r_l + 1'b1;
                    n_state = S_SQ_RD;
                end
            end
            S_SQRT: begin
                if (!sd_busy) begin
                    n_norm = sd_root;
                    n_l    = '0;
                    if (sd_root > {32'd0, r_floor}) begin
                        n_state = S_DIV_RD;
                    end else if (r_j == r_j_last) begin
                        n_out_valid = 1'b1;
                        n_out_kind  = gso_pkg::KIND_DONE;
                        n_out_data  = '0;
                        n_state     = S_IDLE;
                    end else begin
                        n_j     = r_j + 1'b1;
                        n_i     = '0;
                        n_acc   = '0;
                        n_state = S_DOT_RD;
                    end
                end
            end
            S_DIV_RD: n_state = S_DIV_GO;
            S_DIV_GO: begin
                sd_ctrl.start_div = 1'b1;
                n_state           = S_DIV;
            end
            S_DIV: begin
                if (!sd_busy) begin
                    if (r_l != r_l_last) begin
                        n_l     = r_l + 1'b1;
                        n_state = S_DIV_RD;
                    end else if (r_j == r_j_last) begin
                        n_out_valid = 1'b1;
                        n_out_kind  = gso_pkg::KIND_DONE;
                        n_out_data  = '0;
                        n_state     = S_IDLE;
                    end else begin
                        n_l     = '0;
                        n_j     = r_j + 1'b1;
                        n_i     = '0;
                        n_acc   = '0;
                        n_state = S_DOT_RD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state and registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_rows      <= 4'd8;
            r_cols      <= 3'd4;
            r_floor     <= 16'd1;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    gso_pkg::CFG_ROWS:  r_rows  <= i_cfg_data[3:0];
                    gso_pkg::CFG_COLS:  r_cols  <= i_cfg_data[2:0];
                    gso_pkg::CFG_FLOOR: r_floor <= i_cfg_data;
                    default: begin
                        r_floor <= r_floor;
                    end
                endcase
            end
        end
    end

    // payload and loop counters
    always_ff @(posedge i_clk) begin
        r_l        <= n_l;
        r_i        <= n_i;
        r_j        <= n_j;
        r_l_last   <= n_l_last;
        r_j_last   <= n_j_last;
        r_acc      <= n_acc;
        r_coef     <= n_coef;
        r_elem     <= n_elem;
        r_norm     <= n_norm;
        r_in_ok    <= n_in_ok;
        r_out_data <= n_out_data;
        r_out_kind <= n_out_kind;
    end

endmodule
`default_nettype wire

/* src/gso_ram.sv */
// Generic RAM: one write port, two registered read ports.
`default_nettype none
module gso_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_a,
    output logic      [WIDTH-1:0]         o_rdata_a,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic      [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule
`default_nettype wire

/* src/gso_mul.sv */
// Shared two-stage multiplier with round-half-up to the fixed-point grid.
`default_nettype none
module gso_mul #(
    parameter int FRAC_BITS = gso_pkg::GSO_FRAC_BITS
) (
    input  wire logic               i_clk,
    input  wire logic signed [31:0] i_a,
    input  wire logic signed [31:0] i_b,
    output logic signed      [63:0] o_rnd
);

    localparam logic signed [63:0] HALF = 64'sd1 <<< (FRAC_BITS - 1);

    logic signed [63:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= 64'(i_a) * 64'(i_b);
        o_rnd  <= (r_prod + HALF) >>> FRAC_BITS;
    end

endmodule
`default_nettype wire

/* src/gso_sqdiv.sv */
// Bit-serial unit shared by the scaled square root and the quotient.
`default_nettype none
module gso_sqdiv #(
    parameter int FRAC_BITS = gso_pkg::GSO_FRAC_BITS
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire gso_pkg::t_sd_ctrl  i_ctrl,
    input  wire logic        [63:0] i_radicand,
    input  wire logic signed [31:0] i_dividend,
    input  wire logic        [47:0] i_divisor,
    output logic                    o_busy,
    output logic             [47:0] o_root,
    output logic signed      [31:0] o_quot
);

    localparam int XW       = 96;
    localparam int CNT_W    = 7;
    localparam int SQ_STEPS = 48;
    localparam int DV_STEPS = 32 + FRAC_BITS;

    logic             r_busy;
    logic             r_mode_sqrt;
    logic             r_neg;
    logic [CNT_W-1:0] r_cnt;
    logic [XW-1:0]    r_x;
    logic [49:0]      r_rem;
    logic [63:0]      r_res;
    logic [47:0]      r_div;

    logic [51:0] remn;
    logic [51:0] cand;
    logic [52:0] diff;
    logic        ge;
    logic [31:0] mag;

    always_comb begin
        if (r_mode_sqrt) begin
            remn = {r_rem, r_x[XW-1 -: 2]};
            cand = {2'b00, r_res[47:0], 2'b01};
        end else begin
            remn = {1'b0, r_rem, r_x[XW-1]};
            cand = {4'b0000, r_div};
        end
        diff = {1'b0, remn} - {1'b0, cand};
        ge   = !diff[52];
        mag  = i_dividend[31] ? 32'(-i_dividend) : 32'(i_dividend);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_ctrl.start_sqrt || i_ctrl.start_div) begin
            r_busy <= 1'b1;
        end else if (r_busy && r_cnt == '0) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.start_sqrt) begin
            r_mode_sqrt <= 1'b1;
            r_cnt       <= CNT_W'(SQ_STEPS - 1);
            r_x         <= XW'({i_radicand, {FRAC_BITS{1'b0}}});
            r_rem       <= '0;
            r_res       <= '0;
        end else if (i_ctrl.start_div) begin
            r_mode_sqrt <= 1'b0;
            r_cnt       <= CNT_W'(DV_STEPS - 1);
            r_x         <= {mag, {(XW-32){1'b0}}};
            r_rem       <= '0;
            r_res       <= '0;
            r_div       <= i_divisor;
            r_neg       <= i_dividend[31];
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            r_x   <= r_mode_sqrt ? (r_x << 2) : (r_x << 1);
            r_rem <= ge ? diff[49:0] : remn[49:0];
            r_res <= {r_res[62:0], ge};
        end
    end

    assign o_busy = r_busy;
    assign o_root = r_res[47:0];
    assign o_quot = gso_pkg::sat32(r_neg ? -$signed(r_res) : $signed(r_res));

endmodule
`default_nettype wire

/* test/gram_schmidt_orthonormalizer_tb.sv */
// Self-checking testbench of the Gram-Schmidt orthonormaliser: random requests against a predictor.
`timescale 1ns / 100ps
`default_nettype none
module gram_schmidt_orthonormalizer_tb;

    localparam int NR = gso_pkg::GSO_MAX_ROWS;
    localparam int NC = gso_pkg::GSO_MAX_COLS;
    localparam int FB = gso_pkg::GSO_FRAC_BITS;
    localparam int IDLE_LIMIT = 40000;   // longer than the slowest run
    localparam int SETTLE = 40;          // cycles to let a trailing write land

    typedef struct {
        logic [31:0] data;
        logic        kind;
    } t_result;

    // Scoreboard: keeps its own copy of the store and registers, predicts results.
    class gso_scoreboard;
        int          store [NR*NC];
        int unsigned rows_reg, cols_reg, floor_reg;
        t_result     awaited [$];
        int          errors, results_seen, requests_seen, runs_seen;

        function new();
            rows_reg  = 8;
            cols_reg  = 4;
            floor_reg = 1;
            foreach (store[i]) store[i] = 0;
        endfunction

        task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
            errors++;
            $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        endtask

        function void note_config(logic [1:0] idx, logic [15:0] val);
            case (idx)
                gso_pkg::CFG_ROWS:  rows_reg  = val[3:0];
                gso_pkg::CFG_COLS:  cols_reg  = val[2:0];
                gso_pkg::CFG_FLOOR: floor_reg = val;
                default: ;
            endcase
        endfunction

        function longint prod_round(longint a, longint b);
            return (a * b + (64'sd1 <<< (FB - 1))) >>> FB;
        endfunction

        function longint clip32(longint x);
            if (x > 64'sd2147483647) return 64'sd2147483647;
            if (x < -64'sd2147483648) return -64'sd2147483648;
            return x;
        endfunction

        // floor(sqrt(s * 2^FB)), one result bit per step
        function longint unsigned root_scaled(longint unsigned s);
            longint unsigned root, rem, trial;
            int pos;
            logic hi_b, lo_b;
            root = 0;
            rem  = 0;
            for (int p = 47; p >= 0; p--) begin
                pos  = 2 * p + 1;
                hi_b = (pos >= FB && pos - FB < 64) ? s[pos - FB] : 1'b0;
                pos  = 2 * p;
                lo_b = (pos >= FB && pos - FB < 64) ? s[pos - FB] : 1'b0;
                rem   = (rem << 2) | (longint'(hi_b) << 1) | longint'(lo_b);
                trial = (root << 2) | 64'd1;
                if (rem >= trial) begin
                    rem  = rem - trial;
                    root = (root << 1) | 64'd1;
                end else begin
                    root = root << 1;
                end
            end
            return root;
        endfunction

        function void orthonormalise();
            int n, k;
            longint dot, c, a, sumsq, q;
            longint unsigned norm;
            n = (rows_reg < 1) ? 1 : (rows_reg > NR) ? NR : int'(rows_reg);
            k = (cols_reg < 1) ? 1 : (cols_reg > NC) ? NC : int'(cols_reg);
            for (int j = 0; j < k; j++) begin
                for (int i = 0; i < j; i++) begin
                    dot = 0;
                    for (int l = 0; l < n; l++)
                        dot += prod_round(store[l*NC+j], store[l*NC+i]);
                    c = clip32(dot);
                    for (int l = 0; l < n; l++) begin
                        a = store[l*NC+j];
                        a = a - prod_round(c, store[l*NC+i]);
                        store[l*NC+j] = int'(clip32(a));
                    end
                end
                sumsq = 0;
                for (int l = 0; l < n; l++)
                    sumsq += prod_round(store[l*NC+j], store[l*NC+j]);
                norm = root_scaled(longint'(sumsq));
                if (norm > floor_reg) begin
                    for (int l = 0; l < n; l++) begin
                        a = store[l*NC+j];
                        q = (a * (64'sd1 <<< FB)) / longint'(norm);
                        store[l*NC+j] = int'(clip32(q));
                    end
                end
            end
        endfunction

        function void note_request(gso_pkg::t_cmd cmd, logic [2:0] row, logic [1:0] col,
                                   logic [31:0] val);
            t_result r;
            requests_seen++;
            case (cmd)
                gso_pkg::CMD_WRITE: store[int'(row)*NC+int'(col)] = val;
                gso_pkg::CMD_ORTHO: begin
                    orthonormalise();
                    runs_seen++;
                    r.data = '0;
                    r.kind = gso_pkg::KIND_DONE;
                    awaited.push_back(r);
                end
                gso_pkg::CMD_READ: begin
                    r.data = store[int'(row)*NC+int'(col)];
                    r.kind = gso_pkg::KIND_READ;
                    awaited.push_back(r);
                end
                default: ;
            endcase
        endfunction

        task check_result(logic [31:0] data, logic kind);
            t_result w;
            results_seen++;
            if (awaited.size() == 0) begin
                report_mismatch("unexpected result", data, 32'h0);
            end else begin
                w = awaited.pop_front();
                if (kind !== w.kind) report_mismatch("kind", 32'(kind), 32'(w.kind));
                if (data !== w.data) report_mismatch("data", data, w.data);
            end
        endtask
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [39:0] i_s_axis_tdata = '0;
    logic [1:0]  i_s_axis_tuser = '0;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [31:0] o_m_axis_tdata;
    logic        o_m_axis_tuser;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;

    gso_scoreboard sb = new();
    int idle_cycles = 0;
    int phases_run = 0;

    gram_schmidt_orthonormalizer DUT (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Most gaps short, a few long.
    function int gap_len();
        if ($urandom_range(0, 2) == 0) return 0;
        if ($urandom_range(0, 15) == 0) return $urandom_range(20, 60);
        return $urandom_range(1, 3);
    endfunction

    // Result side: stall the receiver at random, with quiet stretches.
    int stall_left = 0;
    int calm_left = 0;
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left = stall_left - 1;
            i_m_axis_tready <= 1'b0;
        end else if (calm_left > 0) begin
            calm_left = calm_left - 1;
            i_m_axis_tready <= 1'b1;
        end else if ($urandom_range(0, 9) == 0) begin
            calm_left = $urandom_range(50, 300);
            i_m_axis_tready <= 1'b1;
        end else begin
            stall_left = gap_len();
            i_m_axis_tready <= 1'b1;
        end
    end

    // Check every accepted result against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            sb.check_result(o_m_axis_tdata, o_m_axis_tuser);
    end

    // Watchdog: end the run if nothing moves for too long.
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)
            || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("watchdog expired at %0t", $realtime);
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // Present one request and hold it until accepted; valid stays high afterwards.
    task send_request(gso_pkg::t_cmd cmd, logic [2:0] row, logic [1:0] col,
                      logic [31:0] val);
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= cmd;
        i_s_axis_tdata  <= {3'b000, val, col, row};
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        sb.note_request(cmd, row, col, val);
    endtask

    // Drop valid for a random gap, or keep streaming.
    task sender_gap();
        int g;
        g = gap_len();
        if (g > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    task send_spaced(gso_pkg::t_cmd cmd, logic [2:0] row, logic [1:0] col,
                     logic [31:0] val);
        send_request(cmd, row, col, val);
        sender_gap();
    endtask

    // Hold off until every predicted result is in, then let trailing writes land.
    task drain();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.awaited.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task write_register(logic [1:0] idx, logic [15:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.note_config(idx, val);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function logic [31:0] pick_value();
        case ($urandom_range(0, 7))
            0: return $urandom;
            1: case ($urandom_range(0, 3))
                   0: return 32'h7FFF_FFFF;
                   1: return 32'h8000_0000;
                   2: return 32'h0;
                   default: return 32'hFFFF_FFFF;
               endcase
            2: return $urandom_range(0, 255) - 32'd128;   // tiny, drives the small-norm case
            default: return $urandom_range(0, 32'h3FFF_FFFF) - 32'h2000_0000;
        endcase
    endfunction

    // One well-formed pass: load the matrix, orthonormalise, read it all back.
    task matrix_pass();
        for (int r = 0; r < NR; r++)
            for (int c = 0; c < NC; c++)
                send_spaced(gso_pkg::CMD_WRITE, 3'(r), 2'(c), pick_value());
        send_spaced(gso_pkg::CMD_ORTHO, 3'($urandom), 2'($urandom), $urandom);
        for (int r = 0; r < NR; r++)
            for (int c = 0; c < NC; c++)
                send_spaced(gso_pkg::CMD_READ, 3'(r), 2'(c), $urandom);
    endtask

    // Noise: stray writes, reads, unused commands and extra runs.
    task noise_burst(int count);
        for (int i = 0; i < count; i++) begin
            case ($urandom_range(0, 9))
                0, 1, 2: send_spaced(gso_pkg::CMD_WRITE, 3'($urandom), 2'($urandom),
                                     pick_value());
                3:       send_spaced(gso_pkg::CMD_NONE, 3'($urandom), 2'($urandom), $urandom);
                4:       send_spaced(gso_pkg::CMD_ORTHO, 3'($urandom), 2'($urandom), $urandom);
                default: send_spaced(gso_pkg::CMD_READ, 3'($urandom), 2'($urandom), $urandom);
            endcase
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: fill the store with extremes, then cover every command.
        for (int r = 0; r < NR; r++)
            for (int c = 0; c < NC; c++)
                case ((r * NC + c) % 6)
                    0: send_request(gso_pkg::CMD_WRITE, 3'(r), 2'(c), 32'h7FFF_FFFF);
                    1: send_request(gso_pkg::CMD_WRITE, 3'(r), 2'(c), 32'h8000_0000);
                    2: send_request(gso_pkg::CMD_WRITE, 3'(r), 2'(c), 32'h1000_0000);
                    3: send_request(gso_pkg::CMD_WRITE, 3'(r), 2'(c), 32'hFFFF_FFFF);
                    4: send_request(gso_pkg::CMD_WRITE, 3'(r), 2'(c), 32'h0);
                    default: send_request(gso_pkg::CMD_WRITE, 3'(r), 2'(c), 32'hAAAA_5555);
                endcase
        send_request(gso_pkg::CMD_READ, 3'd0, 2'd0, 32'h0);
        send_request(gso_pkg::CMD_READ, 3'd7, 2'd3, 32'hFFFF_FFFF);
        send_request(gso_pkg::CMD_NONE, 3'd7, 2'd3, 32'hFFFF_FFFF);
        // zero column keeps its value: the small-norm case
        for (int r = 0; r < NR; r++) send_request(gso_pkg::CMD_WRITE, 3'(r), 2'd2, 32'h0);
        send_request(gso_pkg::CMD_ORTHO, 3'd0, 2'd0, 32'h0);
        send_request(gso_pkg::CMD_READ, 3'd0, 2'd1, 32'h0);
        send_request(gso_pkg::CMD_READ, 3'd5, 2'd2, 32'h0);
        drain();

        // Phases under several settings, extremes and out-of-range values among them.
        for (int ph = 0; ph < 18; ph++) begin
            case (ph)
                0: begin
                    write_register(gso_pkg::CFG_ROWS, 16'd1);
                    write_register(gso_pkg::CFG_COLS, 16'd1);
                    write_register(gso_pkg::CFG_FLOOR, 16'd0);
                end
                1: begin
                    write_register(gso_pkg::CFG_ROWS, 16'hFFFF);
                    write_register(gso_pkg::CFG_COLS, 16'hFFFF);
                    write_register(gso_pkg::CFG_FLOOR, 16'hFFFF);
                end
                2: begin
                    write_register(gso_pkg::CFG_ROWS, 16'd0);
                    write_register(gso_pkg::CFG_COLS, 16'd0);
                    write_register(gso_pkg::CFG_FLOOR, 16'd1);
                end
                3: begin
                    write_register(gso_pkg::CFG_ROWS, 16'd8);
                    write_register(gso_pkg::CFG_COLS, 16'd4);
                    write_register(2'd3, 16'hFFFF);   // unknown index, ignored
                end
                default: begin
                    write_register(gso_pkg::CFG_ROWS, 16'($urandom_range(0, 15)));
                    write_register(gso_pkg::CFG_COLS, 16'($urandom_range(0, 7)));
                    write_register(gso_pkg::CFG_FLOOR, ($urandom_range(0, 3) == 0)
                                   ? 16'($urandom) : 16'($urandom_range(0, 64)));
                end
            endcase
            matrix_pass();
            noise_burst(6);
            phases_run++;
            drain();
        end

        $display("requests %0d, results %0d, orthonormalise runs %0d, phases %0d",
                 sb.requests_seen, sb.results_seen, sb.runs_seen, phases_run);
        $display("covered extreme values, clamped register settings and small norms");
        if (sb.errors == 0 && sb.awaited.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
`default_nettype wire
